>>> rtl/iidl_pkg.sv
package iidl_pkg;

   // List geometry
   localparam int LIST_DEPTH = 16;
   localparam int POS_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

   // Fixed field widths
   localparam int OP_W      = 3;
   localparam int INDEX_W   = 4;
   localparam int DATA_W    = 32;
   localparam int COUNT_F_W = 5;
   localparam int STATUS_W  = 2;

   // Width used to compare an index against the fill count
   localparam int CMP_W = (INDEX_W > CNT_W) ? INDEX_W : CNT_W;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT     = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_APPEND     = 3'd2,
      OP_TAKE_FIRST = 3'd3,
      OP_POP_BACK   = 3'd4,
      OP_REMOVE_AT  = 3'd5,
      OP_CLEAR      = 3'd6,
      OP_READ       = 3'd7
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // Shift command broadcast along the row of cells
   typedef struct packed {
      logic             ins;
      logic             rem;
      logic [POS_W-1:0] pos;
   } cell_cmd_type;

endpackage

>>> rtl/iidl_cell.sv
module iidl_cell (
   input  logic                          clock,
   input  iidl_pkg::cell_cmd_type        cmd,
   input  logic [iidl_pkg::POS_W-1:0]    cell_pos,
   input  logic [iidl_pkg::DATA_W-1:0]   new_value,
   input  logic [iidl_pkg::DATA_W-1:0]   left_data,
   input  logic [iidl_pkg::DATA_W-1:0]   right_data,
   output logic [iidl_pkg::DATA_W-1:0]   data
);
   import iidl_pkg::*;

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   // Pick the next entry: shift up past the insert point, shift down from the removal point
   always_comb begin
      data_in = data_ff;
      if (cmd.ins) begin
         if (cell_pos > cmd.pos) begin
            data_in = left_data;
         end else if (cell_pos == cmd.pos) begin
            data_in = new_value;
         end
      end else if (cmd.rem) begin
         if (cell_pos >= cmd.pos) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

>>> rtl/iidl_ctrl.sv
module iidl_ctrl (
   input  logic                           accept,
   input  logic [iidl_pkg::OP_W-1:0]      op,
   input  logic [iidl_pkg::INDEX_W-1:0]   index,
   input  logic [iidl_pkg::CNT_W-1:0]     count,
   output iidl_pkg::cell_cmd_type         cmd,
   output logic [iidl_pkg::POS_W-1:0]     read_pos,
   output logic                           read_en,
   output iidl_pkg::status_type           status,
   output logic [iidl_pkg::CNT_W-1:0]     count_next
);
   import iidl_pkg::*;

   logic [CMP_W-1:0] idx_cmp;
   logic [CMP_W-1:0] cnt_cmp;
   logic             full;
   logic             empty;
   logic [POS_W-1:0] idx_pos;
   logic [POS_W-1:0] cnt_pos;
   logic [POS_W-1:0] last_pos;
   logic             do_ins;
   logic             do_rem;
   logic [POS_W-1:0] pos;

   assign idx_cmp  = CMP_W'(index);
   assign cnt_cmp  = CMP_W'(count);
   assign full     = (count == CNT_W'(LIST_DEPTH));
   assign empty    = (count == '0);
   assign idx_pos  = POS_W'(index);
   assign cnt_pos  = POS_W'(count);
   assign last_pos = POS_W'(count - CNT_W'(1));

   // Decode the operation into a status and a shift command
   always_comb begin
      status     = ST_OK;
      do_ins     = 1'b0;
      do_rem     = 1'b0;
      pos        = '0;
      read_en    = 1'b0;
      count_next = count;
      case (op_type'(op))
         OP_INSERT: begin
            pos = idx_pos;
            if (full) begin
               status = ST_FULL;
            end else if (idx_cmp > cnt_cmp) begin
               status = ST_RANGE;
            end else begin
               do_ins = 1'b1;
            end
         end
         OP_PUSH_FRONT: begin
            if (full) status = ST_FULL;
            else      do_ins = 1'b1;
         end
         OP_APPEND: begin
            pos = cnt_pos;
            if (full) status = ST_FULL;
            else      do_ins = 1'b1;
         end
         OP_TAKE_FIRST: begin
            if (empty) status = ST_EMPTY;
            else       do_rem = 1'b1;
         end
         OP_POP_BACK: begin
            pos = last_pos;
            if (empty) status = ST_EMPTY;
            else       do_rem = 1'b1;
         end
         OP_REMOVE_AT: begin
            pos = idx_pos;
            if (empty) begin
               status = ST_EMPTY;
            end else if (idx_cmp >= cnt_cmp) begin
               status = ST_RANGE;
            end else begin
               do_rem = 1'b1;
            end
         end
         OP_CLEAR: begin
            count_next = '0;
         end
         OP_READ: begin
            pos = idx_pos;
            if (idx_cmp >= cnt_cmp) status = ST_RANGE;
            else                    read_en = 1'b1;
         end
         default: begin
            status = ST_OK;
         end
      endcase
      if (do_ins) count_next = count + CNT_W'(1);
      if (do_rem) begin
         count_next = count - CNT_W'(1);
         read_en    = 1'b1;
      end
   end

   // Gate the shift command with the transfer
   assign cmd.ins  = do_ins & accept;
   assign cmd.rem  = do_rem & accept;
   assign cmd.pos  = pos;
   assign read_pos = pos;

endmodule

>>> rtl/indexed_insert_delete_list.sv
// Channel   | Ports                                         | Transfer
// ----------+-----------------------------------------------+---------------------------
// request   | start, busy, req_op, req_index, req_value     | start high and busy low
// response  | rsp_valid, rsp_read_data, rsp_count, rsp_status | one cycle with rsp_valid
//
// One operation per cycle: busy stays low, so a request may follow every clock.
// The response appears on the cycle after the request transfer; the row of cells
// shifts in that same edge, so the next request sees the updated list.
// Synchronous active-high reset empties the list; entry contents are not cleared.
// The receiver cannot stall the response: it shows for exactly one cycle.
module indexed_insert_delete_list (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [iidl_pkg::OP_W-1:0]      req_op,
   input  logic [iidl_pkg::INDEX_W-1:0]   req_index,
   input  logic signed [iidl_pkg::DATA_W-1:0] req_value,
   output logic                           rsp_valid,
   output logic signed [iidl_pkg::DATA_W-1:0] rsp_read_data,
   output logic [iidl_pkg::COUNT_F_W-1:0] rsp_count,
   output logic [iidl_pkg::STATUS_W-1:0]  rsp_status
);
   import iidl_pkg::*;

   logic                accept;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   cell_cmd_type        cmd;
   logic [POS_W-1:0]    read_pos;
   logic                read_en;
   status_type          status;
   logic [DATA_W-1:0]   cell_data [LIST_DEPTH];
   logic [DATA_W-1:0]   read_word;

   logic                rsp_valid_ff;
   logic [DATA_W-1:0]   rsp_data_ff;
   logic [DATA_W-1:0]   rsp_data_in;
   logic [COUNT_F_W-1:0] rsp_count_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   iidl_ctrl u_ctrl (
      .accept     (accept),
      .op         (req_op),
      .index      (req_index),
      .count      (count_ff),
      .cmd        (cmd),
      .read_pos   (read_pos),
      .read_en    (read_en),
      .status     (status),
      .count_next (count_in)
   );

   // Row of cells, each handing its entry to its neighbors
   for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
      logic [DATA_W-1:0] left_data;
      logic [DATA_W-1:0] right_data;
      if (k == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_inner_l
         assign left_data = cell_data[k-1];
      end
      if (k == LIST_DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_inner_r
         assign right_data = cell_data[k+1];
      end
      iidl_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_pos   (POS_W'(k)),
         .new_value  (req_value),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[k])
      );
   end

   // Select the entry being read or taken out
   assign read_word   = cell_data[read_pos];
   assign rsp_data_in = read_en ? read_word : '0;

   // Hold the fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   // Register the response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
      end
   end

   // Register the response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_count_ff  <= COUNT_F_W'(count_in);
         rsp_status_ff <= status;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

>>> bench/tb_top.sv
module tb_top;
   import iidl_pkg::*;

   typedef struct {
      op_type                   op;
      logic [INDEX_W-1:0]       index;
      logic signed [DATA_W-1:0] value;
   } list_req_type;

   typedef struct {
      logic signed [DATA_W-1:0] read_data;
      logic [COUNT_F_W-1:0]     count;
      status_type               status;
   } list_rsp_type;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 1950;
   localparam int DRAIN_CYCLES = 8;

   logic                     clock         = 1'b0;
   logic                     reset         = 1'b1;
   logic                     start         = 1'b0;
   logic [OP_W-1:0]          req_op        = '0;
   logic [INDEX_W-1:0]       req_index     = '0;
   logic signed [DATA_W-1:0] req_value     = '0;
   logic                     busy;
   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_read_data;
   logic [COUNT_F_W-1:0]     rsp_count;
   logic [STATUS_W-1:0]      rsp_status;

   // Shadow copy of the list contents and fill level
   logic signed [DATA_W-1:0] shadow_entries [LIST_DEPTH];
   int                       shadow_len = 0;

   // Fill level as seen by the stimulus generator
   int                       gen_len = 0;

   list_req_type             pending_req_q[$];
   list_rsp_type             predicted_rsp_q[$];

   int                       error_count = 0;
   int                       cycle_count = 0;
   int                       burst_left  = 0;
   int                       gap_left    = 0;

   indexed_insert_delete_list DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_index     (req_index),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_read_data (rsp_read_data),
      .rsp_count     (rsp_count),
      .rsp_status    (rsp_status)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Apply one operation to the shadow list and return the response it gives
   function automatic list_rsp_type apply_list_op(op_type op, logic [INDEX_W-1:0] idx,
                                                  logic signed [DATA_W-1:0] val);
      list_rsp_type rsp;
      status_type   st;
      int           pos;
      int           k;
      st = ST_OK;
      rsp.read_data = '0;
      case (op)
         OP_INSERT, OP_PUSH_FRONT, OP_APPEND: begin
            if (op == OP_INSERT) pos = idx;
            else if (op == OP_PUSH_FRONT) pos = 0;
            else pos = shadow_len;
            if (shadow_len >= LIST_DEPTH) begin
               st = ST_FULL;
            end else if (pos > shadow_len) begin
               st = ST_RANGE;
            end else begin
               for (k = shadow_len; k > pos; k--) shadow_entries[k] = shadow_entries[k-1];
               shadow_entries[pos] = val;
               shadow_len++;
            end
         end
         OP_TAKE_FIRST, OP_POP_BACK, OP_REMOVE_AT: begin
            if (op == OP_TAKE_FIRST) pos = 0;
            else if (op == OP_POP_BACK) pos = shadow_len - 1;
            else pos = idx;
            if (shadow_len == 0) begin
               st = ST_EMPTY;
            end else if (pos >= shadow_len) begin
               st = ST_RANGE;
            end else begin
               rsp.read_data = shadow_entries[pos];
               for (k = pos; k < shadow_len - 1; k++) shadow_entries[k] = shadow_entries[k+1];
               shadow_len--;
            end
         end
         OP_CLEAR: begin
            shadow_len = 0;
         end
         default: begin
            if (idx < shadow_len) rsp.read_data = shadow_entries[idx];
            else st = ST_RANGE;
         end
      endcase
      if (st != ST_OK) rsp.read_data = '0;
      rsp.count  = shadow_len[COUNT_F_W-1:0];
      rsp.status = st;
      return rsp;
   endfunction

   // Queue one request and track the fill level it leads to
   function automatic void add_req(op_type op, int idx, logic signed [DATA_W-1:0] val);
      list_req_type r;
      r.op    = op;
      r.index = idx[INDEX_W-1:0];
      r.value = val;
      pending_req_q.insert(pending_req_q.size(), r);
      case (op)
         OP_INSERT:                  if (gen_len < LIST_DEPTH && idx <= gen_len) gen_len++;
         OP_PUSH_FRONT, OP_APPEND:   if (gen_len < LIST_DEPTH) gen_len++;
         OP_TAKE_FIRST, OP_POP_BACK: if (gen_len > 0) gen_len--;
         OP_REMOVE_AT:               if (idx < gen_len) gen_len--;
         OP_CLEAR:                   gen_len = 0;
         default: ;
      endcase
   endfunction

   // Favor extreme words, keep most of them fully random
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Drive requests in bursts separated by random gaps
   always @(posedge clock) begin
      logic offer;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predicted_rsp_q.insert(predicted_rsp_q.size(),
                                   apply_list_op(op_type'(req_op), req_index, req_value));
            pending_req_q.delete(0);
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               burst_left = $urandom_range(1, 24);
            end
         end
         offer = 1'b0;
         if (start && busy) offer = 1'b1;
         else if (gap_left > 0) gap_left--;
         else if (pending_req_q.size() > 0) offer = 1'b1;
         start <= offer;
         if (offer) begin
            req_op    <= pending_req_q[0].op;
            req_index <= pending_req_q[0].index;
            req_value <= pending_req_q[0].value;
         end
      end
   end

   // Check each response transfer against the oldest prediction
   always @(posedge clock) begin
      list_rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (predicted_rsp_q.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response read_data %0d count %0d status %0d",
                     $time, rsp_read_data, rsp_count, rsp_status);
         end else begin
            want = predicted_rsp_q[0];
            predicted_rsp_q.delete(0);
            if (rsp_read_data !== want.read_data) begin
               error_count++;
               $display("%0t: read_data expected %0d actual %0d",
                        $time, want.read_data, rsp_read_data);
            end
            if (rsp_count !== want.count) begin
               error_count++;
               $display("%0t: count expected %0d actual %0d", $time, want.count, rsp_count);
            end
            if (rsp_status !== want.status) begin
               error_count++;
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_status);
            end
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int     k;
      int     roll;
      int     phase_left;
      int     top;
      bit     growing;
      op_type op;

      // Empty list: every removal and read fails, clear still succeeds
      add_req(OP_READ, 0, 0);
      add_req(OP_TAKE_FIRST, 0, 0);
      add_req(OP_POP_BACK, 0, 0);
      add_req(OP_REMOVE_AT, 15, 0);
      add_req(OP_CLEAR, 0, 0);

      // Extreme words, append through insert, insert and remove past the end
      add_req(OP_APPEND, 0, 32'h7FFF_FFFF);
      add_req(OP_PUSH_FRONT, 0, 32'h8000_0000);
      add_req(OP_INSERT, 1, -1);
      add_req(OP_INSERT, 3, 0);
      add_req(OP_INSERT, 5, 32'h1234_5678);
      add_req(OP_READ, 1, 0);
      add_req(OP_READ, 15, 0);
      add_req(OP_REMOVE_AT, 4, 0);
      add_req(OP_REMOVE_AT, 1, 0);

      // Fill up, then hit the full list
      for (k = 0; k < 13; k++) begin
         if (k % 3 == 0) add_req(OP_INSERT, gen_len / 2, $urandom);
         else add_req(op_type'(k % 3), 0, $urandom);
      end
      add_req(OP_APPEND, 0, 32'h5555_5555);
      add_req(OP_INSERT, 15, 32'hAAAA_AAAA);
      add_req(OP_READ, 15, 0);
      add_req(OP_REMOVE_AT, 15, 0);
      add_req(OP_TAKE_FIRST, 0, 0);
      add_req(OP_POP_BACK, 0, 0);

      // Random traffic, alternating between growing and shrinking phases
      growing    = 1'b1;
      phase_left = $urandom_range(10, 60);
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (phase_left == 0) begin
            growing    = !growing;
            phase_left = $urandom_range(10, 60);
         end
         phase_left--;
         roll = $urandom_range(0, 99);
         if (roll < 2) op = OP_CLEAR;
         else if (roll < 17) op = OP_READ;
         else if ((roll < 72) == growing) op = op_type'($urandom_range(0, 2));
         else op = op_type'($urandom_range(3, 5));
         top = (gen_len > 15) ? 15 : gen_len;
         add_req(op, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, top),
                 pick_value());
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Drain all requests and responses, then watch for stray transfers
      while (pending_req_q.size() != 0 || predicted_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
